// ----- hw/rtl/tlc_pkg.sv -----
// package: shared constants, codes and types of the two-level cache tag block
package tlc_pkg;

  localparam int DEF_ADDR_BITS   = 32;
  localparam int DEF_L1_MAX_SETS = 64;
  localparam int DEF_L1_MAX_WAYS = 4;
  localparam int DEF_L2_MAX_SETS = 1024;
  localparam int DEF_L2_MAX_WAYS = 8;

  localparam int APB_AW = 5;

  localparam logic [2:0] REG_BLOCK_BITS     = 3'd0;
  localparam logic [2:0] REG_L1_SET_BITS    = 3'd1;
  localparam logic [2:0] REG_L1_WAY_BITS    = 3'd2;
  localparam logic [2:0] REG_L2_SET_BITS    = 3'd3;
  localparam logic [2:0] REG_L2_WAY_BITS    = 3'd4;
  localparam logic [2:0] REG_WRITE_ALLOCATE = 3'd5;

  localparam logic [3:0] RST_BLOCK_BITS     = 4'd4;
  localparam logic [2:0] RST_L1_SET_BITS    = 3'd6;
  localparam logic [1:0] RST_L1_WAY_BITS    = 2'd2;
  localparam logic [3:0] RST_L2_SET_BITS    = 4'd10;
  localparam logic [1:0] RST_L2_WAY_BITS    = 2'd3;
  localparam logic       RST_WRITE_ALLOCATE = 1'b1;

  typedef enum logic [1:0] {
    OP_TOUCH,
    OP_FILL,
    OP_REMOVE
  } set_op_t;

  typedef struct packed {
    logic hit;
    logic victim;
  } set_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1_RD,
    ST_L1_EVAL,
    ST_L2_EVAL,
    ST_BI_RD,
    ST_BI_EVAL,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/tlc_set_ram.sv -----
// one-port-read one-port-write set memory with registered read data
module tlc_set_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/tlc_set_ops.sv -----
// set row logic: tag lookup, lru touch, fill with victim choice, removal
module tlc_set_ops import tlc_pkg::*; #(
  parameter int WAYS = 4,
  parameter int RW   = 2,
  parameter int TW   = 32
) (
  input  set_op_t                   op,
  input  logic [RW-1:0]             ways_m1,
  input  logic [TW-1:0]             tag,
  input  logic [WAYS*(1+RW+TW)-1:0] row_in,
  output logic [WAYS*(1+RW+TW)-1:0] row_out,
  output set_res_t                  res,
  output logic [TW-1:0]             vtag
);

  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic          v  [WAYS];
  logic [RW-1:0] rk [WAYS];
  logic [TW-1:0] tg [WAYS];
  logic          nv [WAYS];
  logic [RW-1:0] nr [WAYS];
  logic [TW-1:0] nt [WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      v[w]  = row_in[w];
      rk[w] = row_in[WAYS + w*RW +: RW];
      tg[w] = row_in[WAYS + WAYS*RW + w*TW +: TW];
    end
  end

  always_comb begin
    logic [WAYS-1:0] used;
    logic [WAYS-1:0] match;
    logic [WW-1:0]   hw;
    logic [WW-1:0]   pick;
    logic            found;
    logic [RW-1:0]   r;
    hw    = '0;
    pick  = '0;
    found = 1'b0;
    r     = '0;
    for (int w = 0; w < WAYS; w++) begin
      used[w]  = RW'(w) <= ways_m1;
      match[w] = used[w] && v[w] && (tg[w] == tag);
    end
    for (int w = WAYS-1; w >= 0; w--) begin
      if (match[w]) begin
        hw = WW'(w);
      end
      if (used[w] && !v[w]) begin
        pick  = WW'(w);
        found = 1'b1;
      end
    end
    if (!found) begin
      pick = '0;
      for (int w = 1; w < WAYS; w++) begin
        if (used[w] && (rk[w] > rk[pick])) begin
          pick = WW'(w);
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      nv[w] = v[w];
      nr[w] = rk[w];
      nt[w] = tg[w];
    end
    unique case (op)
      OP_TOUCH: begin
        r = rk[hw];
        for (int w = 0; w < WAYS; w++) begin
          if (used[w] && (WW'(w) != hw) && v[w] && (rk[w] < r)) begin
            nr[w] = rk[w] + RW'(1);
          end
        end
        nr[hw] = '0;
      end
      OP_FILL: begin
        for (int w = 0; w < WAYS; w++) begin
          if (used[w] && (WW'(w) != pick) && v[w] && (rk[w] < ways_m1)) begin
            nr[w] = rk[w] + RW'(1);
          end
        end
        nt[pick] = tag;
        nv[pick] = 1'b1;
        nr[pick] = '0;
      end
      OP_REMOVE: begin
        r = rk[hw];
        for (int w = 0; w < WAYS; w++) begin
          if (used[w] && (WW'(w) != hw) && v[w] && (rk[w] > r)) begin
            nr[w] = rk[w] - RW'(1);
          end
        end
        nv[hw] = 1'b0;
        nr[hw] = '0;
      end
      default: begin
      end
    endcase
    res.hit    = |match;
    res.victim = !found;
    vtag       = tg[pick];
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_out[w]                          = nv[w];
      row_out[WAYS + w*RW +: RW]          = nr[w];
      row_out[WAYS + WAYS*RW + w*TW +: TW] = nt[w];
    end
  end

endmodule

// ----- hw/rtl/two_level_inclusive_lru_cache_tags.sv -----
// top level: two-level inclusive lru cache tag controller with apb registers
//
//   channel  direction  handshake                 word
//   in       input      in_valid / in_ready       command, address
//   out      output     out_valid / out_ready     hit, victim and back-invalidate flags, l2 victim address
//   cfg      input      psel / penable / pready   register write and read
//
// one access at a time: the l1 set row is read, then on an l1 miss the l2 row, and
// when an l2 victim is chosen its l1 row is read for back-invalidation; each set
// row read is registered and each update is a read-modify-write of the set memory
// after reset a clearing pass writes every set row of both memories to zero
// before the first access is taken
// a result waits in the output register; a new access is taken meanwhile
module two_level_inclusive_lru_cache_tags import tlc_pkg::*; #(
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int L1_MAX_SETS = DEF_L1_MAX_SETS,
  parameter int L1_MAX_WAYS = DEF_L1_MAX_WAYS,
  parameter int L2_MAX_SETS = DEF_L2_MAX_SETS,
  parameter int L2_MAX_WAYS = DEF_L2_MAX_WAYS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [31:0]       address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              l1_hit,
  output logic              l2_accessed,
  output logic              l2_hit,
  output logic              l1_victim_valid,
  output logic              l2_victim_valid,
  output logic [31:0]       l2_victim_address,
  output logic              back_invalidated,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int L1_IW  = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
  localparam int L2_IW  = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
  localparam int L1_SBM = $clog2(L1_MAX_SETS + 1) - 1;
  localparam int L2_SBM = $clog2(L2_MAX_SETS + 1) - 1;
  localparam int L1_WBM = $clog2(L1_MAX_WAYS + 1) - 1;
  localparam int L2_WBM = $clog2(L2_MAX_WAYS + 1) - 1;
  localparam int RW1    = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
  localparam int RW2    = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
  localparam int DW1    = L1_MAX_WAYS * (1 + RW1 + ADDR_BITS);
  localparam int DW2    = L2_MAX_WAYS * (1 + RW2 + ADDR_BITS);
  localparam int CLR_D  = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
  localparam int CW     = (CLR_D > 1) ? $clog2(CLR_D) : 1;

  logic [3:0] block_bits;
  logic [2:0] l1_set_bits;
  logic [1:0] l1_way_bits;
  logic [3:0] l2_set_bits;
  logic [1:0] l2_way_bits;
  logic       write_allocate;

  state_t state, state_next;
  logic [CW-1:0] cnt;

  logic                 cmd_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic                 r_l1h, r_l2a, r_l2h, r_l1v, r_l2v, r_binv;
  logic [ADDR_BITS-1:0] r_vaddr;

  logic [4:0] s1b, s2b;
  logic [2:0] w1b, w2b;
  logic [5:0] sh1, sh2;
  logic [RW1-1:0] l1_wm1;
  logic [RW2-1:0] l2_wm1;
  logic [ADDR_BITS-1:0] bs, vbs, tag1, tag2, vtag1, vaddr_n;
  logic [L1_IW-1:0] set1, vset1;
  logic [L2_IW-1:0] set2;
  logic alloc;

  logic             l1_re, l1_we, l2_re, l2_we;
  logic [L1_IW-1:0] l1_ra, l1_wa;
  logic [L2_IW-1:0] l2_ra, l2_wa;
  logic [DW1-1:0]   l1_rd, l1_wd, l1_row_out;
  logic [DW2-1:0]   l2_rd, l2_wd, l2_row_out;
  set_op_t          l1_op, l2_op;
  logic [ADDR_BITS-1:0] l1_tag, l1_vtag, l2_vtag;
  set_res_t         l1_res, l2_res;
  logic             out_load;
  logic             cfg_we;
  logic [2:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_comb begin
    unique case (cfg_idx)
      REG_BLOCK_BITS:     prdata = 32'(block_bits);
      REG_L1_SET_BITS:    prdata = 32'(l1_set_bits);
      REG_L1_WAY_BITS:    prdata = 32'(l1_way_bits);
      REG_L2_SET_BITS:    prdata = 32'(l2_set_bits);
      REG_L2_WAY_BITS:    prdata = 32'(l2_way_bits);
      REG_WRITE_ALLOCATE: prdata = 32'(write_allocate);
      default:            prdata = '0;
    endcase
  end

  // geometry clipped to what the memories hold
  always_comb begin
    s1b = (32'(l1_set_bits) > 32'(L1_SBM)) ? 5'(L1_SBM) : 5'(l1_set_bits);
    s2b = (32'(l2_set_bits) > 32'(L2_SBM)) ? 5'(L2_SBM) : 5'(l2_set_bits);
    w1b = (32'(l1_way_bits) > 32'(L1_WBM)) ? 3'(L1_WBM) : 3'(l1_way_bits);
    w2b = (32'(l2_way_bits) > 32'(L2_WBM)) ? 3'(L2_WBM) : 3'(l2_way_bits);
    l1_wm1 = RW1'((32'd1 << w1b) - 32'd1);
    l2_wm1 = RW2'((32'd1 << w2b) - 32'd1);
    sh1 = 6'(block_bits) + 6'(s1b);
    sh2 = 6'(block_bits) + 6'(s2b);
    bs    = addr_r >> block_bits;
    set1  = L1_IW'(bs & ((ADDR_BITS'(1) << s1b) - ADDR_BITS'(1)));
    set2  = L2_IW'(bs & ((ADDR_BITS'(1) << s2b) - ADDR_BITS'(1)));
    tag1  = addr_r >> sh1;
    tag2  = addr_r >> sh2;
    vbs   = r_vaddr >> block_bits;
    vset1 = L1_IW'(vbs & ((ADDR_BITS'(1) << s1b) - ADDR_BITS'(1)));
    vtag1 = r_vaddr >> sh1;
    vaddr_n = (l2_vtag << sh2) | (ADDR_BITS'(set2) << block_bits);
    alloc = !cmd_r || write_allocate;
  end

  tlc_set_ram #(.DEPTH(L1_MAX_SETS), .AW(L1_IW), .DW(DW1)) u_l1_ram (
    .clk(clk), .rd_en(l1_re), .rd_addr(l1_ra), .rd_data(l1_rd),
    .wr_en(l1_we), .wr_addr(l1_wa), .wr_data(l1_wd)
  );

  tlc_set_ram #(.DEPTH(L2_MAX_SETS), .AW(L2_IW), .DW(DW2)) u_l2_ram (
    .clk(clk), .rd_en(l2_re), .rd_addr(l2_ra), .rd_data(l2_rd),
    .wr_en(l2_we), .wr_addr(l2_wa), .wr_data(l2_wd)
  );

  tlc_set_ops #(.WAYS(L1_MAX_WAYS), .RW(RW1), .TW(ADDR_BITS)) u_l1_ops (
    .op(l1_op), .ways_m1(l1_wm1), .tag(l1_tag), .row_in(l1_rd),
    .row_out(l1_row_out), .res(l1_res), .vtag(l1_vtag)
  );

  tlc_set_ops #(.WAYS(L2_MAX_WAYS), .RW(RW2), .TW(ADDR_BITS)) u_l2_ops (
    .op(l2_op), .ways_m1(l2_wm1), .tag(tag2), .row_in(l2_rd),
    .row_out(l2_row_out), .res(l2_res), .vtag(l2_vtag)
  );

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    l1_re = 1'b0;
    l1_ra = set1;
    l1_we = 1'b0;
    l1_wa = set1;
    l1_wd = l1_row_out;
    l2_re = 1'b0;
    l2_ra = set2;
    l2_we = 1'b0;
    l2_wa = set2;
    l2_wd = l2_row_out;
    l1_op  = OP_TOUCH;
    l1_tag = tag1;
    l2_op  = l2_res.hit ? OP_TOUCH : OP_FILL;
    unique case (state)
      ST_CLEAR: begin
        l1_we = 32'(cnt) < 32'(L1_MAX_SETS);
        l1_wa = cnt[L1_IW-1:0];
        l1_wd = '0;
        l2_we = 32'(cnt) < 32'(L2_MAX_SETS);
        l2_wa = cnt[L2_IW-1:0];
        l2_wd = '0;
        if (cnt == CW'(CLR_D - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_L1_RD;
        end
      end
      ST_L1_RD: begin
        l1_re = 1'b1;
        state_next = ST_L1_EVAL;
      end
      ST_L1_EVAL: begin
        if (l1_res.hit) begin
          l1_we = 1'b1;
          state_next = ST_DONE;
        end else begin
          l2_re = 1'b1;
          state_next = ST_L2_EVAL;
        end
      end
      ST_L2_EVAL: begin
        l1_op = OP_FILL;
        l2_we = l2_res.hit || alloc;
        l1_we = alloc;
        if (!l2_res.hit && alloc && l2_res.victim) begin
          state_next = ST_BI_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_BI_RD: begin
        l1_re = 1'b1;
        l1_ra = vset1;
        state_next = ST_BI_EVAL;
      end
      ST_BI_EVAL: begin
        l1_op  = OP_REMOVE;
        l1_tag = vtag1;
        l1_wa  = vset1;
        l1_we  = l1_res.hit;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      cnt            <= '0;
      out_valid      <= 1'b0;
      block_bits     <= RST_BLOCK_BITS;
      l1_set_bits    <= RST_L1_SET_BITS;
      l1_way_bits    <= RST_L1_WAY_BITS;
      l2_set_bits    <= RST_L2_SET_BITS;
      l2_way_bits    <= RST_L2_WAY_BITS;
      write_allocate <= RST_WRITE_ALLOCATE;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        cnt <= cnt + CW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_BLOCK_BITS:     block_bits     <= pwdata[3:0];
          REG_L1_SET_BITS:    l1_set_bits    <= pwdata[2:0];
          REG_L1_WAY_BITS:    l1_way_bits    <= pwdata[1:0];
          REG_L2_SET_BITS:    l2_set_bits    <= pwdata[3:0];
          REG_L2_WAY_BITS:    l2_way_bits    <= pwdata[1:0];
          REG_WRITE_ALLOCATE: write_allocate <= pwdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= command;
      addr_r  <= ADDR_BITS'(address);
      r_l1h   <= 1'b0;
      r_l2a   <= 1'b0;
      r_l2h   <= 1'b0;
      r_l1v   <= 1'b0;
      r_l2v   <= 1'b0;
      r_binv  <= 1'b0;
      r_vaddr <= '0;
    end
    if (state == ST_L1_EVAL) begin
      r_l1h <= l1_res.hit;
      r_l2a <= !l1_res.hit;
    end
    if (state == ST_L2_EVAL) begin
      r_l2h   <= l2_res.hit;
      r_l1v   <= alloc && l1_res.victim;
      r_l2v   <= !l2_res.hit && alloc && l2_res.victim;
      r_vaddr <= (!l2_res.hit && alloc && l2_res.victim) ? vaddr_n : '0;
    end
    if (state == ST_BI_EVAL) begin
      r_binv <= l1_res.hit;
    end
    if (out_load) begin
      l1_hit            <= r_l1h;
      l2_accessed       <= r_l2a;
      l2_hit            <= r_l2h;
      l1_victim_valid   <= r_l1v;
      l2_victim_valid   <= r_l2v;
      l2_victim_address <= 32'(r_vaddr);
      back_invalidated  <= r_binv;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the two-level inclusive lru cache tag block: self-checking, apb setup
`timescale 1ns / 1ps
module testbench import tlc_pkg::*;;

  typedef struct packed {
    logic        l1_hit;
    logic        l2_accessed;
    logic        l2_hit;
    logic        l1_victim_valid;
    logic        l2_victim_valid;
    logic [31:0] l2_victim_address;
    logic        back_invalidated;
  } access_outcome_t;

  localparam int STORE_DEPTH = 8192;
  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = 1'b0;
  logic [31:0]       address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              l1_hit;
  logic              l2_accessed;
  logic              l2_hit;
  logic              l1_victim_valid;
  logic              l2_victim_valid;
  logic [31:0]       l2_victim_address;
  logic              back_invalidated;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  two_level_inclusive_lru_cache_tags dut (.*);

  always #6 clk = ~clk;

  // shadow copy of both tag levels, level 0 is l1 and level 1 is l2
  logic [31:0] shadow_tag [2][STORE_DEPTH];
  bit          shadow_valid [2][STORE_DEPTH];
  int unsigned shadow_rank [2][STORE_DEPTH];
  int unsigned max_ways [2] = '{DEF_L1_MAX_WAYS, DEF_L2_MAX_WAYS};

  int unsigned cfg_block = RST_BLOCK_BITS;
  int unsigned cfg_l1_sets = RST_L1_SET_BITS;
  int unsigned cfg_l1_ways = RST_L1_WAY_BITS;
  int unsigned cfg_l2_sets = RST_L2_SET_BITS;
  int unsigned cfg_l2_ways = RST_L2_WAY_BITS;
  bit          cfg_wr_alloc = RST_WRITE_ALLOCATE;

  access_outcome_t pending_outcomes [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned idle_cycles = 0;
  logic [31:0] addr_pool [16];

  function automatic int unsigned clamp_bits(int unsigned bits, int unsigned limit);
    while (bits > 0 && (1 << bits) > limit) bits--;
    return bits;
  endfunction

  function automatic int find_line(int lv, int unsigned set, int unsigned ways,
                                   logic [31:0] tag);
    for (int unsigned w = 0; w < ways; w++) begin
      if (shadow_valid[lv][set*max_ways[lv]+w] && shadow_tag[lv][set*max_ways[lv]+w] == tag)
        return w;
    end
    return -1;
  endfunction

  function automatic void promote(int lv, int unsigned set, int unsigned ways,
                                  int unsigned way);
    int unsigned base;
    int unsigned r;
    base = set * max_ways[lv];
    r = shadow_rank[lv][base+way];
    for (int unsigned w = 0; w < ways; w++) begin
      if (w != way && shadow_valid[lv][base+w] && shadow_rank[lv][base+w] < r)
        shadow_rank[lv][base+w]++;
    end
    shadow_rank[lv][base+way] = 0;
  endfunction

  function automatic bit allocate_line(int lv, int unsigned set, int unsigned ways,
                                       logic [31:0] tag, output logic [31:0] vtag);
    int unsigned base;
    int unsigned pick;
    bit found;
    base = set * max_ways[lv];
    pick = 0;
    found = 1'b0;
    vtag = '0;
    for (int unsigned w = 0; w < ways && !found; w++) begin
      if (!shadow_valid[lv][base+w]) begin
        pick = w;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int unsigned w = 1; w < ways; w++)
        if (shadow_rank[lv][base+w] > shadow_rank[lv][base+pick]) pick = w;
      vtag = shadow_tag[lv][base+pick];
    end
    for (int unsigned w = 0; w < ways; w++) begin
      if (w != pick && shadow_valid[lv][base+w] && shadow_rank[lv][base+w] + 1 < ways)
        shadow_rank[lv][base+w]++;
    end
    shadow_tag[lv][base+pick] = tag;
    shadow_valid[lv][base+pick] = 1'b1;
    shadow_rank[lv][base+pick] = 0;
    return !found;
  endfunction

  function automatic void drop_line(int lv, int unsigned set, int unsigned ways,
                                    int unsigned way);
    int unsigned base;
    int unsigned r;
    base = set * max_ways[lv];
    r = shadow_rank[lv][base+way];
    shadow_valid[lv][base+way] = 1'b0;
    shadow_rank[lv][base+way] = 0;
    for (int unsigned w = 0; w < ways; w++) begin
      if (shadow_valid[lv][base+w] && shadow_rank[lv][base+w] > r)
        shadow_rank[lv][base+w]--;
    end
  endfunction

  function automatic access_outcome_t predict_access(logic cmd, logic [31:0] a);
    access_outcome_t o;
    int unsigned s1b, s2b, w1, w2, set1, set2, vs;
    logic [63:0] addr64, vaddr;
    logic [31:0] tag1, tag2, vt, vt1;
    bit alloc;
    int way, vw;
    o = '0;
    addr64 = {32'd0, a};
    s1b = clamp_bits(cfg_l1_sets, DEF_L1_MAX_SETS);
    s2b = clamp_bits(cfg_l2_sets, DEF_L2_MAX_SETS);
    w1 = 1 << clamp_bits(cfg_l1_ways, DEF_L1_MAX_WAYS);
    w2 = 1 << clamp_bits(cfg_l2_ways, DEF_L2_MAX_WAYS);
    set1 = 32'((addr64 >> cfg_block) & 64'((1 << s1b) - 1));
    set2 = 32'((addr64 >> cfg_block) & 64'((1 << s2b) - 1));
    tag1 = 32'(addr64 >> (cfg_block + s1b));
    tag2 = 32'(addr64 >> (cfg_block + s2b));
    alloc = !cmd || cfg_wr_alloc;
    vaddr = '0;
    way = find_line(0, set1, w1, tag1);
    if (way >= 0) begin
      o.l1_hit = 1'b1;
      promote(0, set1, w1, way);
    end else begin
      o.l2_accessed = 1'b1;
      way = find_line(1, set2, w2, tag2);
      if (way >= 0) begin
        o.l2_hit = 1'b1;
        promote(1, set2, w2, way);
      end else if (alloc) begin
        o.l2_victim_valid = allocate_line(1, set2, w2, tag2, vt);
        if (o.l2_victim_valid)
          vaddr = ({32'd0, vt} << (cfg_block + s2b)) | (64'(set2) << cfg_block);
      end
      if (alloc) o.l1_victim_valid = allocate_line(0, set1, w1, tag1, vt);
      if (o.l2_victim_valid) begin
        vs = 32'((vaddr >> cfg_block) & 64'((1 << s1b) - 1));
        vt1 = 32'(vaddr >> (cfg_block + s1b));
        vw = find_line(0, vs, w1, vt1);
        if (vw >= 0) begin
          drop_line(0, vs, w1, vw);
          o.back_invalidated = 1'b1;
        end
      end
    end
    o.l2_victim_address = vaddr[31:0];
    return o;
  endfunction

  task automatic send_access(logic cmd, logic [31:0] a);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    command <= cmd;
    address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outcomes.push_back(predict_access(cmd, a));
    burst_left--;
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned bb, int unsigned s1, int unsigned w1,
                              int unsigned s2, int unsigned w2, bit wa);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    apb_write(REG_BLOCK_BITS, bb);
    apb_write(REG_L1_SET_BITS, s1);
    apb_write(REG_L1_WAY_BITS, w1);
    apb_write(REG_L2_SET_BITS, s2);
    apb_write(REG_L2_WAY_BITS, w2);
    apb_write(REG_WRITE_ALLOCATE, 32'(wa));
    cfg_block = bb;
    cfg_l1_sets = s1;
    cfg_l1_ways = w1;
    cfg_l2_sets = s2;
    cfg_l2_ways = w2;
    cfg_wr_alloc = wa;
    burst_left = 0;
    for (int k = 0; k < 16; k++)
      addr_pool[k] = ($urandom_range(0, 7) << 20) | ($urandom_range(0, 3) << 12) |
                     ($urandom_range(0, 3) << cfg_block) | ($urandom & 32'hF000_0000);
  endtask

  task automatic random_accesses(int unsigned count);
    logic [31:0] a;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) a = $urandom;
      else a = addr_pool[$urandom_range(0, 15)] ^ ($urandom & ((1 << cfg_block) - 1));
      send_access(1'($urandom_range(0, 1)), a);
    end
  endtask

  task automatic test_reset_geometry();
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0008);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFF0);
    send_access(1'b1, 32'h0001_0000);
    send_access(1'b0, 32'h0001_0004);
    random_accesses(60);
  endtask

  task automatic test_single_line();
    set_geometry(0, 0, 0, 0, 0, 1'b1);
    send_access(1'b0, 32'h0000_0001);
    send_access(1'b0, 32'h0000_0001);
    send_access(1'b0, 32'h8000_0000);
    send_access(1'b1, 32'h0000_0001);
    random_accesses(40);
  endtask

  task automatic test_back_invalidation();
    set_geometry(2, 0, 2, 0, 0, 1'b1);
    send_access(1'b0, 32'h0000_0010);
    send_access(1'b0, 32'h0000_0020);
    send_access(1'b0, 32'h0000_0010);
    send_access(1'b1, 32'h0000_0030);
    random_accesses(50);
  endtask

  task automatic test_no_write_allocate();
    set_geometry(4, 0, 0, 2, 1, 1'b0);
    send_access(1'b0, 32'h0000_1000);
    send_access(1'b0, 32'h0000_2000);
    send_access(1'b1, 32'h0000_1000);
    send_access(1'b1, 32'h0000_3000);
    send_access(1'b0, 32'h0000_3000);
    random_accesses(60);
  endtask

  task automatic test_oversized_geometry();
    set_geometry(15, 7, 3, 15, 3, 1'b1);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h0000_0000);
    random_accesses(40);
    set_geometry(8, 6, 2, 10, 3, 1'b0);
    random_accesses(40);
  endtask

  task automatic test_geometry_changes();
    for (int p = 0; p < 5; p++) begin
      set_geometry($urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 2),
                   $urandom_range(0, 4), $urandom_range(0, 3), 1'($urandom_range(0, 1)));
      random_accesses(25);
    end
  endtask

  // result checker and stall pattern
  int unsigned stall_mode = 0;
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    access_outcome_t got, want;
    cycle_count++;
    if (!rst && out_valid && out_ready) begin
      got = '{l1_hit, l2_accessed, l2_hit, l1_victim_valid, l2_victim_valid,
              l2_victim_address, back_invalidated};
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (cycle_count % 5 < 2);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_single_line();
    test_back_invalidation();
    test_no_write_allocate();
    test_oversized_geometry();
    test_geometry_changes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
